@@ design/address_range_subtract_assert.svh @@
// Assertion macros for the address range subtract block.
// Included by the top level; expects clk and rst in scope.
`ifndef ADDRESS_RANGE_SUBTRACT_ASSERT_SVH
`define ADDRESS_RANGE_SUBTRACT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ARS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define ARS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/ars_pkg.sv @@
// Shared types, codes and helpers for the address range subtract block.
// No dependencies.
package ars_pkg;

  localparam int unsigned HALF_W = 64;
  localparam int unsigned ADDR_W = 2 * HALF_W;

  typedef logic [ADDR_W-1:0] addr_t;

  // IPv4 addresses live in the low 32 bits
  localparam addr_t V4_MASK = {96'd0, 32'hFFFF_FFFF};

  typedef enum logic [1:0] {
    OUT_UNCHANGED = 2'd0,
    OUT_TRIMMED   = 2'd1,
    OUT_SPLIT     = 2'd2,
    OUT_BAD_CUT   = 2'd3
  } outcome_t;

  typedef enum logic [2:0] {
    REG_CUT_LOW_UPPER  = 3'd0,
    REG_CUT_LOW_LOWER  = 3'd1,
    REG_CUT_HIGH_UPPER = 3'd2,
    REG_CUT_HIGH_LOWER = 3'd3,
    REG_V4_MODE        = 3'd4
  } reg_idx_t;

  typedef struct packed {
    addr_t    low;
    addr_t    high;
    outcome_t outcome;
    logic     last;
  } res_t;

  // Classifier result: how many beats (0..2) and their contents
  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } cls_t;

  function automatic addr_t addr_mask(addr_t a, logic v4);
    return v4 ? (a & V4_MASK) : a;
  endfunction

endpackage

@@ design/ars_entry_if.sv @@
// Input channel: one stored address range per beat.
// Valid/ready handshake; no package dependency.
interface ars_entry_if;
  logic        valid;
  logic        ready;
  logic [63:0] entry_low_upper;
  logic [63:0] entry_low_lower;
  logic [63:0] entry_high_upper;
  logic [63:0] entry_high_lower;

  modport source (output valid, entry_low_upper, entry_low_lower,
                  entry_high_upper, entry_high_lower, input ready);
  modport sink   (input valid, entry_low_upper, entry_low_lower,
                  entry_high_upper, entry_high_lower, output ready);
endinterface

@@ design/ars_result_if.sv @@
// Output channel: one kept range per beat with outcome and last flag.
// Valid/ready handshake; no package dependency.
interface ars_result_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_low_upper;
  logic [63:0] out_low_lower;
  logic [63:0] out_high_upper;
  logic [63:0] out_high_lower;
  logic [1:0]  outcome;
  logic        last_part;

  modport source (output valid, out_low_upper, out_low_lower, out_high_upper,
                  out_high_lower, outcome, last_part, input ready);
  modport sink   (input valid, out_low_upper, out_low_lower, out_high_upper,
                  out_high_lower, outcome, last_part, output ready);
endinterface

@@ design/ars_classify.sv @@
// Combinational range subtraction for one entry against the cut range.
// Depends on ars_pkg.
module ars_classify (
  input  logic          v4,
  input  ars_pkg::addr_t cut_low_raw,
  input  ars_pkg::addr_t cut_high_raw,
  input  ars_pkg::addr_t ent_low_raw,
  input  ars_pkg::addr_t ent_high_raw,
  output ars_pkg::cls_t  cls
);
  import ars_pkg::*;

  addr_t cl, ch, el, eh;
  addr_t cl_m1, ch_p1;
  logic  cut_bad, below, above, low_below, high_above;

  always_comb begin
    cl = addr_mask(cut_low_raw, v4);
    ch = addr_mask(cut_high_raw, v4);
    el = addr_mask(ent_low_raw, v4);
    eh = addr_mask(ent_high_raw, v4);
    // only used where the entry bound lies beyond them, so no wrap
    cl_m1 = addr_mask(cl - addr_t'(1), v4);
    ch_p1 = addr_mask(ch + addr_t'(1), v4);

    cut_bad    = cl > ch;
    below      = eh < cl;
    above      = el > ch;
    low_below  = el < cl;
    high_above = eh > ch;
  end

  always_comb begin
    cls        = '0;
    cls.count  = 2'd1;
    cls.first  = '{low: el, high: eh, outcome: OUT_UNCHANGED, last: 1'b1};
    cls.second = '{low: ch_p1, high: eh, outcome: OUT_SPLIT, last: 1'b1};
    priority if (cut_bad) begin
      cls.first.outcome = OUT_BAD_CUT;
    end else if (below || above) begin
      cls.first.outcome = OUT_UNCHANGED;
    end else if (low_below && high_above) begin
      cls.count = 2'd2;
      cls.first = '{low: el, high: cl_m1, outcome: OUT_SPLIT, last: 1'b0};
    end else if (low_below) begin
      cls.first = '{low: el, high: cl_m1, outcome: OUT_TRIMMED, last: 1'b1};
    end else if (high_above) begin
      cls.first = '{low: ch_p1, high: eh, outcome: OUT_TRIMMED, last: 1'b1};
    end else begin
      // entry wholly inside the cut range
      cls.count = 2'd0;
    end
  end

endmodule

@@ design/address_range_subtract.sv @@
// Top level of the address range subtract block.
// Depends on ars_pkg, ars_entry_if, ars_result_if, ars_classify and the assert header.
//
// Usage:
//  - in_ch carries one address range per beat (start and end, each as an
//    upper and lower 64-bit half). out_ch returns the kept pieces.
//  - The cut range and v4_mode are set over the APB-style port (8-byte
//    registers at 0x00..0x20). Write them only while the block is drained.
//  - Per entry: no beat (fully covered), one beat (unchanged, trimmed, or
//    invalid cut flagged), or two beats (split; first has last_part = 0).
//  - Path: an accepted entry passes the input register, the classifier logic
//    and the result register before its first result beat shows.
//  - Throughput: one entry per cycle while out_ch.ready is high. A split entry
//    holds the single result register for both beats; the input stalls behind it.
//  - Stalls: a result waits in the output register while out_ch.ready is low;
//    one more entry sits in the input register meanwhile, then in_ch.ready
//    drops. A split's second half waits in a side register.
//  - Reset (rst, synchronous): pipeline empties, cut range clears to zero,
//    v4_mode returns to 1.
`include "address_range_subtract_assert.svh"

module address_range_subtract (
  input  logic                clk,
  input  logic                rst,
  ars_entry_if.sink           in_ch,
  ars_result_if.source        out_ch,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [5:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready
);
  import ars_pkg::*;

  // config registers
  logic [63:0] cut_low_upper, cut_low_lower, cut_high_upper, cut_high_lower;
  logic        v4_mode;
  logic [2:0]  reg_sel;
  logic        cfg_wr;

  // input register stage
  logic  a_valid;
  addr_t a_low, a_high;

  // result register plus side register for the second half of a split
  logic  o_valid, p_valid;
  res_t  o_res, p_res;

  logic  a_adv, o_free;
  cls_t  cls;

  assign pready  = 1'b1;
  assign reg_sel = paddr[5:3];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cut_low_upper  <= '0;
      cut_low_lower  <= '0;
      cut_high_upper <= '0;
      cut_high_lower <= '0;
      v4_mode        <= 1'b1;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_CUT_LOW_UPPER:  cut_low_upper  <= pwdata;
        REG_CUT_LOW_LOWER:  cut_low_lower  <= pwdata;
        REG_CUT_HIGH_UPPER: cut_high_upper <= pwdata;
        REG_CUT_HIGH_LOWER: cut_high_lower <= pwdata;
        REG_V4_MODE:        v4_mode        <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_CUT_LOW_UPPER:  prdata = cut_low_upper;
      REG_CUT_LOW_LOWER:  prdata = cut_low_lower;
      REG_CUT_HIGH_UPPER: prdata = cut_high_upper;
      REG_CUT_HIGH_LOWER: prdata = cut_high_lower;
      REG_V4_MODE:        prdata = {63'd0, v4_mode};
      default:            prdata = '0;
    endcase
  end

  ars_classify u_classify (
    .v4           (v4_mode),
    .cut_low_raw  ({cut_low_upper, cut_low_lower}),
    .cut_high_raw ({cut_high_upper, cut_high_lower}),
    .ent_low_raw  (a_low),
    .ent_high_raw (a_high),
    .cls          (cls)
  );

  // output register can be loaded this cycle
  assign o_free = !o_valid || out_ch.ready;
  // stage A hands its entry over; a pending split half goes first
  assign a_adv  = a_valid && !p_valid && o_free;
  assign in_ch.ready = !a_valid || a_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      o_valid <= 1'b0;
      p_valid <= 1'b0;
    end else begin
      if (in_ch.ready) a_valid <= in_ch.valid;
      if (p_valid && o_free) begin
        o_valid <= 1'b1;
        p_valid <= 1'b0;
      end else if (a_adv) begin
        o_valid <= cls.count != 2'd0;
        p_valid <= cls.count == 2'd2;
      end else if (out_ch.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      a_low  <= {in_ch.entry_low_upper, in_ch.entry_low_lower};
      a_high <= {in_ch.entry_high_upper, in_ch.entry_high_lower};
    end
    if (p_valid && o_free) begin
      o_res <= p_res;
    end else if (a_adv) begin
      o_res <= cls.first;
      p_res <= cls.second;
    end
  end

  assign out_ch.valid          = o_valid;
  assign out_ch.out_low_upper  = o_res.low[ADDR_W-1:HALF_W];
  assign out_ch.out_low_lower  = o_res.low[HALF_W-1:0];
  assign out_ch.out_high_upper = o_res.high[ADDR_W-1:HALF_W];
  assign out_ch.out_high_lower = o_res.high[HALF_W-1:0];
  assign out_ch.outcome        = o_res.outcome;
  assign out_ch.last_part      = o_res.last;

  // a pending split half always sits behind a valid first half
  `ARS_ASSERT_NOW(a_pend_behind_out, p_valid, o_valid, "split half pending without output beat")
  // a non-final beat is the first half of a split and its partner is queued
  `ARS_ASSERT_NOW(a_first_half, o_valid && !o_res.last,
                  p_valid && o_res.outcome == OUT_SPLIT, "non-final beat without split partner")
  // the queued half is presented as the final beat once the first is taken
  `ARS_ASSERT_NEXT(a_second_follows, p_valid && out_ch.ready,
                   o_valid && o_res.last && !p_valid, "split second half not forwarded")

endmodule

@@ sim/address_range_subtract_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for address_range_subtract: cut range set over APB, entry
// ranges in, kept pieces out, checked against an in-bench range subtractor.
// Depends on ars_pkg, ars_entry_if, ars_result_if and the block itself.
module address_range_subtract_tb;
  import ars_pkg::*;

  // Cycles with no beat on either channel before the run is declared hung. The slowest
  // correct gap is roughly one sender gap, two stalled result beats and the trip through
  // the pipeline, so this leaves a wide margin.
  localparam int QUIET_LIMIT  = 1000;
  // The pipe is an input and a result register. A fully covered entry produces no beat, so we
  // wait this long past the last expected beat before touching registers or finishing.
  localparam int DRAIN_CYCLES = 8;

  // Tracks the cut settings, predicts the pieces of each entry and checks result beats
  // in order.
  class range_scoreboard;
    logic [63:0] cut_low_up, cut_low_lo, cut_high_up, cut_high_lo;
    logic        v4;
    res_t        pieces_due[$];
    int          errors;
    int          entries;
    int          dropped;
    int          beats[4];

    function new();
      cut_low_up  = '0;
      cut_low_lo  = '0;
      cut_high_up = '0;
      cut_high_lo = '0;
      v4          = 1'b1;
      errors      = 0;
      entries     = 0;
      dropped     = 0;
      beats       = '{default: 0};
    endfunction

    function void write_reg(reg_idx_t idx, logic [63:0] val);
      case (idx)
        REG_CUT_LOW_UPPER:  cut_low_up  = val;
        REG_CUT_LOW_LOWER:  cut_low_lo  = val;
        REG_CUT_HIGH_UPPER: cut_high_up = val;
        REG_CUT_HIGH_LOWER: cut_high_lo = val;
        REG_V4_MODE:        v4          = val[0];
        default: ;
      endcase
    endfunction

    // IPv4 keeps only the low 32 bits; the rest reads as zero
    function addr_t narrow(addr_t a);
      return v4 ? {96'd0, a[31:0]} : a;
    endfunction

    function void add_piece(addr_t lo, addr_t hi, outcome_t oc, logic fin);
      res_t r;
      r.low     = lo;
      r.high    = hi;
      r.outcome = oc;
      r.last    = fin;
      pieces_due.push_back(r);
    endfunction

    // Subtract the cut range from one entry and queue the pieces it leaves.
    function void note_entry(addr_t lo_in, addr_t hi_in);
      addr_t el, eh, cl, ch;
      bit    below, above, low_in, high_in;
      int    before_n;
      el = narrow(lo_in);
      eh = narrow(hi_in);
      cl = narrow({cut_low_up, cut_low_lo});
      ch = narrow({cut_high_up, cut_high_lo});
      before_n = pieces_due.size();
      entries++;
      if (cl > ch) begin
        add_piece(el, eh, OUT_BAD_CUT, 1'b1);
      end else if (eh < cl || el > ch) begin
        add_piece(el, eh, OUT_UNCHANGED, 1'b1);
      end else begin
        below   = el < cl;
        above   = eh > ch;
        high_in = eh >= cl && eh <= ch;
        low_in  = el >= cl && el <= ch;
        // the stepped bounds cannot wrap: an entry bound lies strictly beyond them
        if (below && above) begin
          add_piece(el, narrow(cl - 1), OUT_SPLIT, 1'b0);
          add_piece(narrow(ch + 1), eh, OUT_SPLIT, 1'b1);
        end else if (below && high_in) begin
          add_piece(el, narrow(cl - 1), OUT_TRIMMED, 1'b1);
        end else if (low_in && above) begin
          add_piece(narrow(ch + 1), eh, OUT_TRIMMED, 1'b1);
        end else if (!(!below && eh <= ch)) begin
          add_piece(el, eh, OUT_UNCHANGED, 1'b1);
        end
      end
      if (pieces_due.size() == before_n) dropped++;
    endfunction

    function void check_field(string name, logic [63:0] exp, logic [63:0] got);
      if (got !== exp) begin
        $error("%s: expected %h, got %h", name, exp, got);
        errors++;
      end
    endfunction

    function void check_result(res_t got);
      res_t exp;
      if (pieces_due.size() == 0) begin
        $error("result beat with nothing expected: low %h high %h", got.low, got.high);
        errors++;
        return;
      end
      exp = pieces_due.pop_front();
      beats[exp.outcome]++;
      check_field("out_low_upper", exp.low[127:64], got.low[127:64]);
      check_field("out_low_lower", exp.low[63:0], got.low[63:0]);
      check_field("out_high_upper", exp.high[127:64], got.high[127:64]);
      check_field("out_high_lower", exp.high[63:0], got.high[63:0]);
      check_field("outcome", exp.outcome, got.outcome);
      check_field("last_part", exp.last, got.last);
    endfunction

    function int pending();
      return pieces_due.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [5:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  ars_entry_if  in_ch();
  ars_result_if out_ch();

  range_scoreboard sb;

  // Cut range of the current phase, already narrowed in IPv4 mode; steers pick_point
  bit    cut_v4;
  addr_t cut_lo;
  addr_t cut_hi;
  int    phase_no;
  bit    no_gaps;       // phases with back-to-back beats on both sides
  int    quiet_cycles;

  address_range_subtract dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Everything is sampled right at the rising edge, so it sees the values from before
  // that edge's updates: a beat counts when valid and ready were both high.
  always @(posedge clk) begin : beat_monitor
    bit   moved;
    res_t got;
    moved = 1'b0;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        sb.note_entry({in_ch.entry_low_upper, in_ch.entry_low_lower},
                      {in_ch.entry_high_upper, in_ch.entry_high_lower});
        moved = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        got.low     = {out_ch.out_low_upper, out_ch.out_low_lower};
        got.high    = {out_ch.out_high_upper, out_ch.out_high_lower};
        got.outcome = outcome_t'(out_ch.outcome);
        got.last    = out_ch.last_part;
        sb.check_result(got);
        moved = 1'b1;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("hung: no beat for %0d cycles, %0d pieces outstanding",
                 quiet_cycles, sb.pending());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Result side: draw a stall before every beat, then hold ready until a beat lands.
  initial begin : result_sink
    int stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  function automatic addr_t rand_addr();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  // Half the points sit on or next to the cut bounds, so trims, splits and touching ranges
  // come up often; the rest: space extremes, points inside the cut, plain random addresses.
  function automatic addr_t pick_point();
    addr_t p;
    addr_t r;
    r = rand_addr();
    case ($urandom_range(0, 11))
      0:       p = '0;
      1:       p = '1;
      2:       p = cut_lo;
      3:       p = cut_lo - 1;
      4:       p = cut_lo + 1;
      5:       p = cut_hi;
      6:       p = cut_hi - 1;
      7:       p = cut_hi + 1;
      8, 9:    p = (cut_hi > cut_lo && (cut_hi - cut_lo) != '1) ?
                   cut_lo + r % (cut_hi - cut_lo + 1) : r;
      default: p = r;
    endcase
    // IPv4 ignores the upper bits: half the time fill them with junk
    if (cut_v4) p[127:32] = $urandom_range(0, 1) ? {$urandom, $urandom, $urandom} : '0;
    return p;
  endfunction

  // One entry beat: optional idle gap, then hold valid until ready was seen high.
  task automatic push_entry(addr_t lo, addr_t hi);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.entry_low_upper  <= lo[127:64];
    in_ch.entry_low_lower  <= lo[63:0];
    in_ch.entry_high_upper <= hi[127:64];
    in_ch.entry_high_lower <= hi[63:0];
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_random(int n);
    addr_t lo, hi, t;
    for (int i = 0; i < n; i++) begin
      lo = pick_point();
      hi = pick_point();
      // mostly ordered ranges; some reversed ones are left in on purpose
      if (lo > hi && $urandom_range(0, 7) != 0) begin
        t  = lo;
        lo = hi;
        hi = t;
      end
      push_entry(lo, hi);
    end
  endtask

  // Stop sending, wait for the next edge so the last accepted entry has been noted, let every
  // expected piece arrive, then give a dropped entry still in flight time to leave.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the register takes the value at the edge that ends
  // the access. psel stays up across back-to-back writes and is dropped by the caller.
  task automatic reg_write(reg_idx_t idx, logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, val);
  endtask

  // New cut setting for the next phase; every register is written each time.
  task automatic set_cut(bit v4, addr_t cl, addr_t ch);
    addr_t cl_w, ch_w;
    wait_drained();
    phase_no++;
    no_gaps = (phase_no % 3 == 2);
    cl_w = cl;
    ch_w = ch;
    if (v4) begin
      // junk above bit 31 must not matter in IPv4 mode
      cl_w[127:32] = {$urandom, $urandom, $urandom};
      ch_w[127:32] = {$urandom, $urandom, $urandom};
    end
    reg_write(REG_V4_MODE, {63'd0, v4});
    reg_write(REG_CUT_LOW_UPPER, cl_w[127:64]);
    reg_write(REG_CUT_LOW_LOWER, cl_w[63:0]);
    reg_write(REG_CUT_HIGH_UPPER, ch_w[127:64]);
    reg_write(REG_CUT_HIGH_LOWER, ch_w[63:0]);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cut_v4 = v4;
    cut_lo = v4 ? {96'd0, cl[31:0]} : cl;
    cut_hi = v4 ? {96'd0, ch[31:0]} : ch;
  endtask

  initial begin : stimulus
    logic [31:0] a4, b4;
    logic [63:0] a64;
    addr_t       r1, r2;
    sb           = new();
    phase_no     = 0;
    no_gaps      = 1'b0;
    quiet_cycles = 0;
    rst                    <= 1'b1;
    in_ch.valid            <= 1'b0;
    in_ch.entry_low_upper  <= '0;
    in_ch.entry_low_lower  <= '0;
    in_ch.entry_high_upper <= '0;
    in_ch.entry_high_lower <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // --- directed: IPv4 cut 0x1000..0x1fff, one entry per kind of overlap ---
    set_cut(1'b1, 128'h1000, 128'h1fff);
    push_entry(128'h0, 128'h0fff);                     // just below
    push_entry(128'h2000, 128'hffff_ffff);             // just above, up to the top
    push_entry(128'h1000, 128'h1fff);                  // exactly the cut: dropped
    push_entry(128'h1200, 128'h1300);                  // inside: dropped
    push_entry(128'h0800, 128'h1800);                  // overlaps the start: trimmed
    push_entry(128'h1800, 128'h3000);                  // overlaps the end: trimmed
    push_entry({96'hffff_ffff_ffff_ffff_ffff_ffff, 32'h0}, '1);  // whole space: split
    push_entry(128'h1800, 128'h1200);                  // reversed, inside: dropped
    push_entry(128'h2500, 128'h1500);                  // reversed, start past cut

    // --- directed: IPv6, bounds that borrow and carry across the 64-bit halves ---
    set_cut(1'b0, {64'h1, 64'h0}, {64'h5, 64'hffff_ffff_ffff_ffff});
    push_entry('0, '1);
    push_entry({64'h0, 64'h5}, {64'h3, 64'h7});
    push_entry({64'h2, 64'h0}, {64'h7, 64'h0});
    push_entry({64'h0, 64'h0}, {64'h1, 64'h0});
    push_entry({64'h5, 64'hffff_ffff_ffff_ffff}, {64'h9, 64'h0});
    push_entry({64'h0, 64'h9}, {64'h0, 64'hffff_ffff_ffff_ffff});

    // --- directed: start above end flags every entry ---
    set_cut(1'b1, 128'h10, 128'h0f);
    push_entry({64'hdead_beef_0000_0001, 64'h1234_5678_0000_0000}, 128'h5);
    push_entry('1, '0);

    // --- directed: IPv4 cut over the whole space drops everything ---
    set_cut(1'b1, 128'h0, 128'hffff_ffff);
    push_entry({96'h1, 32'h0}, {96'h2, 32'h0});
    push_entry('1, '1);

    // --- random phases, extremes of the cut among them ---
    a4 = $urandom_range(0, 32'hffff_0000);
    set_cut(1'b1, {96'd0, a4}, {96'd0, a4 + 32'($urandom_range(0, 4096))});
    send_random(45);
    set_cut(1'b1, 128'h0, 128'hffff_ffff);
    send_random(35);
    set_cut(1'b1, 128'h0, 128'h0);
    send_random(35);
    set_cut(1'b1, 128'hffff_ffff, 128'hffff_ffff);
    send_random(35);
    a4 = $urandom | 32'h1;
    set_cut(1'b1, {96'd0, a4}, {96'd0, a4 - 32'($urandom_range(1, 64)) + 32'h0});
    send_random(35);

    a64 = {$urandom, $urandom};
    set_cut(1'b0, {a64, 64'h0},
            {a64 + 64'($urandom_range(0, 3)), 64'hffff_ffff_ffff_ffff});
    send_random(50);
    set_cut(1'b0, '0, '1);
    send_random(35);
    r1 = rand_addr() | {64'h1, 64'h0};
    set_cut(1'b0, r1, r1 - 1 - 128'($urandom_range(0, 100)));
    send_random(35);
    r1 = rand_addr();
    r2 = rand_addr();
    if (r1 > r2) set_cut(1'b0, r2, r1);
    else set_cut(1'b0, r1, r2);
    send_random(50);
    r1 = {$urandom, $urandom, 64'hffff_ffff_ffff_ffff};
    set_cut(1'b0, r1, r1);
    send_random(35);
    a4 = $urandom;
    b4 = $urandom;
    if (a4 > b4) set_cut(1'b1, {96'd0, b4}, {96'd0, a4});
    else set_cut(1'b1, {96'd0, a4}, {96'd0, b4});
    send_random(45);

    wait_drained();
    $display("%0d ranges under %0d cut settings: %0d dropped, %0d unchanged, %0d trimmed",
             sb.entries, phase_no, sb.dropped, sb.beats[OUT_UNCHANGED],
             sb.beats[OUT_TRIMMED]);
    $display("%0d split pieces and %0d beats flagged for a reversed cut",
             sb.beats[OUT_SPLIT], sb.beats[OUT_BAD_CUT]);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/ars_pkg.sv
design/ars_entry_if.sv
design/ars_result_if.sv
design/ars_classify.sv
design/address_range_subtract.sv
sim/address_range_subtract_tb.sv
